FILE: rtl/box_mean_filter_clamped_unit_assert.svh
`ifndef BOX_MEAN_FILTER_CLAMPED_UNIT_ASSERT_SVH
`define BOX_MEAN_FILTER_CLAMPED_UNIT_ASSERT_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/bmf_pkg.sv
package bmf_pkg;

   localparam int PIX_BITS      = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_WRITE,
      S_CHECK,
      S_BACK,
      S_READ,
      S_ACC,
      S_DIV,
      S_DONE
   } bmf_state_type;

   typedef struct packed {
      logic take;
      logic start;
      logic write;
      logic setup;
      logic back;
      logic read;
      logic acc;
      logic div_step;
      logic emit;
   } bmf_cmd_type;

   typedef struct packed {
      logic active;
      logic item_fill;
      logic due;
      logic back_done;
      logic win_last;
      logic div_last;
      logic out_free;
   } bmf_status_type;

endpackage

FILE: rtl/bmf_ctrl.sv
module bmf_ctrl import bmf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  bmf_status_type stat,
   output bmf_cmd_type    cmd
);

   bmf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            if (!stat.active && stat.item_fill) state_in = S_IDLE;
            else state_in = S_WRITE;
         end
         S_WRITE: state_in = S_CHECK;
         S_CHECK: begin
            if (stat.due) state_in = S_BACK;
            else state_in = S_IDLE;
         end
         S_BACK: begin
            if (stat.back_done) state_in = S_READ;
         end
         S_READ: state_in = S_ACC;
         S_ACC: begin
            if (stat.win_last) state_in = S_DIV;
            else state_in = S_READ;
         end
         S_DIV: begin
            if (stat.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:  cmd.take = 1'b1;
         S_START: cmd.start = !stat.active && !stat.item_fill;
         S_WRITE: cmd.write = 1'b1;
         S_CHECK: cmd.setup = stat.due;
         S_BACK:  cmd.back = !stat.back_done;
         S_READ:  cmd.read = 1'b1;
         S_ACC:   cmd.acc = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_DONE:  cmd.emit = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: rtl/bmf_dp.sv
module bmf_dp import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   input  logic [7:0]               req_pixel_in,
   input  logic                     req_filler,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_mean_out,
   output logic                     rsp_frame_last,
   input  bmf_cmd_type              cmd,
   output bmf_status_type           stat
);

   localparam int WIN   = 2 * MAX_RADIUS + 1;
   localparam int DEPTH = WIN * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int DW    = $clog2(WIN + 1);
   localparam int NW    = $clog2(WIN * WIN + 1);
   localparam int SW    = $clog2(WIN * WIN * ((1 << PIX_BITS) - 1) + 1);
   localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
   localparam int HW    = LW + 1;
   localparam int IW    = $clog2(SW + 1);

   function automatic logic [AW-1:0] addr_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (a < b) t = t + (AW+1)'(DEPTH);
      return t[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= (AW+1)'(DEPTH)) t = t - (AW+1)'(DEPTH);
      return t[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
   endfunction

   // configuration
   logic [10:0] cfg_width_ff;
   logic [15:0] cfg_height_ff;
   logic [2:0]  cfg_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 11'd1024;
         cfg_height_ff <= 16'd1;
         cfg_radius_ff <= 3'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:   cfg_width_ff  <= csr_wdata[10:0];
            REG_FRAME_HEIGHT:  cfg_height_ff <= csr_wdata[15:0];
            REG_WINDOW_RADIUS: cfg_radius_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] w_sel;
   logic [15:0]   h_sel;
   logic [RW-1:0] r_sel;

   always_comb begin
      if (cfg_width_ff == '0) w_sel = CW'(1);
      else if (32'(cfg_width_ff) > MAX_WIDTH) w_sel = CW'(MAX_WIDTH);
      else w_sel = CW'(cfg_width_ff);
      h_sel = (cfg_height_ff == '0) ? 16'd1 : cfg_height_ff;
      if (32'(cfg_radius_ff) > MAX_RADIUS) r_sel = RW'(MAX_RADIUS);
      else r_sel = RW'(cfg_radius_ff);
   end

   // registers
   logic [PIX_BITS-1:0] mem [DEPTH];
   logic [PIX_BITS-1:0] rd_ff;

   logic                item_fill_ff, item_fill_in;
   logic [PIX_BITS-1:0] item_pix_ff, item_pix_in;
   logic                active_ff, active_in;
   logic [CW-1:0]       cur_w_ff, cur_w_in;
   logic [15:0]         cur_h_ff, cur_h_in;
   logic [RW-1:0]       cur_r_ff, cur_r_in;
   logic [LW-1:0]       lat_ff, lat_in;
   logic [15:0]         in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]       in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [AW-1:0]       in_addr_ff, in_addr_in, out_addr_ff, out_addr_in;
   logic [HW-1:0]       ahead_ff, ahead_in;
   logic [AW-1:0]       base_ff, base_in, ptr_ff, ptr_in;
   logic [RW-1:0]       rowsub_ff, rowsub_in;
   logic [DW-1:0]       row_left_ff, row_left_in, col_left_ff, col_left_in;
   logic [DW-1:0]       ncols_ff, ncols_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       quo_ff, quo_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [IW-1:0]       div_cnt_ff, div_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          mean_ff, mean_in;
   logic                last_ff, last_in;

   // helpers
   logic          do_write;
   logic [RW-1:0] up_r, dn_r, lf_c, rt_c;
   logic [15:0]   h_rem;
   logic [CW-1:0] w_rem;
   logic [AW-1:0] w_addr, next_base;
   logic [NW:0]   trial;
   logic          ge;
   logic          col_wrap, frame_end;

   always_comb begin
      w_addr = AW'(cur_w_ff);
      do_write = cmd.write && (in_row_ff < cur_h_ff) && !item_fill_ff;

      up_r  = (32'(out_row_ff) >= 32'(cur_r_ff)) ? cur_r_ff : RW'(out_row_ff);
      h_rem = cur_h_ff - 16'd1 - out_row_ff;
      dn_r  = (32'(h_rem) >= 32'(cur_r_ff)) ? cur_r_ff : RW'(h_rem);
      lf_c  = (32'(out_col_ff) >= 32'(cur_r_ff)) ? cur_r_ff : RW'(out_col_ff);
      w_rem = cur_w_ff - CW'(1) - out_col_ff;
      rt_c  = (32'(w_rem) >= 32'(cur_r_ff)) ? cur_r_ff : RW'(w_rem);

      next_base = addr_add(base_ff, w_addr);
      trial = {rem_ff, quo_ff[SW-1]};
      ge = trial >= {1'b0, cnt_ff};

      col_wrap  = (32'(out_col_ff) + 32'd1) >= 32'(cur_w_ff);
      frame_end = col_wrap && ((32'(out_row_ff) + 32'd1) >= 32'(cur_h_ff));
   end

   always_comb begin
      item_fill_in = item_fill_ff;
      item_pix_in  = item_pix_ff;
      active_in    = active_ff;
      cur_w_in     = cur_w_ff;
      cur_h_in     = cur_h_ff;
      cur_r_in     = cur_r_ff;
      lat_in       = LW'(LW'(cur_r_ff) * LW'(cur_w_ff) + LW'(cur_r_ff));
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_addr_in   = in_addr_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_addr_in  = out_addr_ff;
      ahead_in     = ahead_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      rowsub_in    = rowsub_ff;
      row_left_in  = row_left_ff;
      col_left_in  = col_left_ff;
      ncols_in     = ncols_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mean_in      = mean_ff;
      last_in      = last_ff;

      if (cmd.take && req_valid) begin
         item_fill_in = req_filler;
         item_pix_in  = req_pixel_in[PIX_BITS-1:0];
      end

      if (cmd.start) begin
         active_in   = 1'b1;
         cur_w_in    = w_sel;
         cur_h_in    = h_sel;
         cur_r_in    = r_sel;
         in_row_in   = '0;
         in_col_in   = '0;
         in_addr_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_addr_in = '0;
         ahead_in    = '0;
      end

      if (do_write) begin
         in_addr_in = addr_inc(in_addr_ff);
         ahead_in   = ahead_ff + HW'(1);
         if ((32'(in_col_ff) + 32'd1) >= 32'(cur_w_ff)) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 16'd1;
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end

      if (cmd.setup) begin
         base_in     = addr_sub(out_addr_ff, AW'(lf_c));
         ptr_in      = addr_sub(out_addr_ff, AW'(lf_c));
         rowsub_in   = up_r;
         row_left_in = DW'(up_r) + DW'(dn_r) + DW'(1);
         col_left_in = DW'(lf_c) + DW'(rt_c) + DW'(1);
         ncols_in    = DW'(lf_c) + DW'(rt_c) + DW'(1);
         sum_in      = '0;
         cnt_in      = '0;
      end

      if (cmd.back) begin
         base_in   = addr_sub(base_ff, w_addr);
         ptr_in    = addr_sub(base_ff, w_addr);
         rowsub_in = rowsub_ff - RW'(1);
      end

      if (cmd.acc) begin
         sum_in = sum_ff + SW'(rd_ff);
         cnt_in = cnt_ff + NW'(1);
         if (col_left_ff != DW'(1)) begin
            ptr_in      = addr_inc(ptr_ff);
            col_left_in = col_left_ff - DW'(1);
         end else if (row_left_ff != DW'(1)) begin
            base_in     = next_base;
            ptr_in      = next_base;
            col_left_in = ncols_ff;
            row_left_in = row_left_ff - DW'(1);
         end else begin
            quo_in     = sum_ff + SW'(rd_ff);
            rem_in     = '0;
            div_cnt_in = IW'(SW - 1);
         end
      end

      if (cmd.div_step) begin
         rem_in     = ge ? NW'(trial - {1'b0, cnt_ff}) : NW'(trial);
         quo_in     = {quo_ff[SW-2:0], ge};
         div_cnt_in = div_cnt_ff - IW'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         mean_in      = 8'(quo_ff[PIX_BITS-1:0]);
         last_in      = frame_end;
         out_addr_in  = addr_inc(out_addr_ff);
         ahead_in     = ahead_ff - HW'(1);
         if (col_wrap) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 16'd1;
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
         if (frame_end) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_fill_ff <= item_fill_in;
      item_pix_ff  <= item_pix_in;
      cur_w_ff     <= cur_w_in;
      cur_h_ff     <= cur_h_in;
      cur_r_ff     <= cur_r_in;
      lat_ff       <= lat_in;
      in_row_ff    <= in_row_in;
      in_col_ff    <= in_col_in;
      in_addr_ff   <= in_addr_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_addr_ff  <= out_addr_in;
      ahead_ff     <= ahead_in;
      base_ff      <= base_in;
      ptr_ff       <= ptr_in;
      rowsub_ff    <= rowsub_in;
      row_left_ff  <= row_left_in;
      col_left_ff  <= col_left_in;
      ncols_ff     <= ncols_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      mean_ff      <= mean_in;
      last_ff      <= last_in;
   end

   // pixel line store
   always_ff @(posedge clock) begin
      if (do_write) mem[in_addr_ff] <= item_pix_ff;
      if (cmd.read) rd_ff <= mem[ptr_ff];
   end

   always_comb begin
      stat.active    = active_ff;
      stat.item_fill = item_fill_ff;
      stat.due       = (in_row_ff >= cur_h_ff) || (ahead_ff > HW'(lat_ff));
      stat.back_done = rowsub_ff == '0;
      stat.win_last  = (col_left_ff == DW'(1)) && (row_left_ff == DW'(1));
      stat.div_last  = div_cnt_ff == '0;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_out   = mean_ff;
   assign rsp_frame_last = last_ff;

endmodule

FILE: rtl/box_mean_filter_clamped_unit.sv
// channel   direction  handshake                    payload
// req       in         req_valid / req_ready        req_pixel_in, req_filler
// rsp       out        rsp_valid / rsp_ready        rsp_mean_out, rsp_frame_last
// csr       in         csr_we (no wait)             csr_index, csr_wdata
//
// A transaction with no result steps through accept, start, store and check; a
// filler taken outside a frame ends after start. A result adds a rewind over
// the window rows above the output row, a read and an accumulate step per
// window pixel (one-port line store, registered read), the restoring divider at
// one bit of the window sum per cycle, and the load of the output register.
// Reset is synchronous and clears the controller, frame-active flag and output valid.
// A stalled rsp holds the controller only at the load of the next result; req is taken until then.
module box_mean_filter_clamped_unit import bmf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_pixel_in,
   input  logic                     req_filler,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_mean_out,
   output logic                     rsp_frame_last
);

   bmf_cmd_type    cmd;
   bmf_status_type stat;

   bmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmf_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_pixel_in   (req_pixel_in),
      .req_filler     (req_filler),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_mean_out   (rsp_mean_out),
      .rsp_frame_last (rsp_frame_last),
      .cmd            (cmd),
      .stat           (stat)
   );

   assign req_ready = cmd.take;

endmodule

FILE: rtl/bmf_checker.sv
`include "box_mean_filter_clamped_unit_assert.svh"

module bmf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_mean_out,
   input logic       rsp_frame_last
);

   `BMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BMF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({rsp_mean_out, rsp_frame_last}))
   `BMF_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
   `BMF_ASSERT_NOW(a_load_when_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind box_mean_filter_clamped_unit bmf_checker u_bmf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_mean_out   (rsp_mean_out),
   .rsp_frame_last (rsp_frame_last)
);
